### sv/cdte_pkg.sv
// shared widths, constants, types and month table for the civil date to epoch converter
`default_nettype none
package cdte_pkg;

   localparam int YearW  = 16;
   localparam int MonthW = 4;
   localparam int DayW   = 5;
   localparam int HourW  = 5;
   localparam int MinW   = 6;
   localparam int SecW   = 6;
   localparam int EpochW = 42;

   localparam int Latency = 7;

   localparam int UW      = 17;
   localparam int QW      = 8;
   localparam int YoeW    = 9;
   localparam int DoyW    = 9;
   localparam int TodW    = 17;
   localparam int DoeW    = 18;
   localparam int QmulW   = 25;
   localparam int DaysW   = 26;

   localparam int YearBias    = 32800;
   localparam int EraYears    = 400;
   localparam int EraDays     = 146097;
   localparam int DaysOffset  = 12699422;
   localparam int YearDays    = 365;
   localparam int DaySecs     = 86400;
   localparam int HourSecs    = 3600;
   localparam int MinSecs     = 60;

   localparam int RecipEra    = 5243;
   localparam int RecipEraSh  = 17;
   localparam int RecipCent   = 164;
   localparam int RecipCentSh = 12;

   typedef struct packed {
      logic            ok;
      logic [UW-1:0]   ybias;
      logic [DoyW-1:0] doy;
      logic [TodW-1:0] tod;
   } front_type;

   typedef struct packed {
      logic                    ok;
      logic signed [DaysW-1:0] days;
      logic [TodW-1:0]         tod;
   } days_type;

   function automatic logic [DoyW-1:0] month_offset(input logic [MonthW-1:0] month);
      logic [DoyW-1:0] off;
      case (month)
         4'd1:    off = DoyW'(306);
         4'd2:    off = DoyW'(337);
         4'd3:    off = DoyW'(0);
         4'd4:    off = DoyW'(31);
         4'd5:    off = DoyW'(61);
         4'd6:    off = DoyW'(92);
         4'd7:    off = DoyW'(122);
         4'd8:    off = DoyW'(153);
         4'd9:    off = DoyW'(184);
         4'd10:   off = DoyW'(214);
         4'd11:   off = DoyW'(245);
         4'd12:   off = DoyW'(275);
         default: off = DoyW'(0);
      endcase
      return off;
   endfunction

endpackage
`default_nettype wire

### sv/cdte_front.sv
// input stage: range check, march-based year bias, day of year and time of day
`default_nettype none
module cdte_front (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_vld,
   input  wire [cdte_pkg::YearW-1:0]       year,
   input  wire [cdte_pkg::MonthW-1:0]      month,
   input  wire [cdte_pkg::DayW-1:0]        day,
   input  wire [cdte_pkg::HourW-1:0]       hour,
   input  wire [cdte_pkg::MinW-1:0]        minute,
   input  wire [cdte_pkg::SecW-1:0]        second,
   output logic                            out_vld,
   output cdte_pkg::front_type             out_word
);
   import cdte_pkg::*;

   logic            vld_ff;
   front_type       word_ff;
   front_type       word_in;
   logic [UW:0]     y_adj;

   always_comb begin
      y_adj = {{(UW + 1 - YearW){year[YearW-1]}}, year}
              - (UW + 1)'(month <= MonthW'(2));
      y_adj = y_adj + (UW + 1)'(YearBias);
      word_in.ybias = y_adj[UW-1:0];
      word_in.ok    = (month inside {[4'd1:4'd12]}) && (day != DayW'(0))
                      && (hour <= HourW'(23)) && (minute <= MinW'(59))
                      && (second <= SecW'(60));
      word_in.doy   = month_offset(month) + DoyW'(day) - DoyW'(1);
      word_in.tod   = TodW'(hour) * TodW'(HourSecs) + TodW'(minute) * TodW'(MinSecs)
                      + TodW'(second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_vld  = vld_ff;
   assign out_word = word_ff;

endmodule
`default_nettype wire

### sv/cdte_days.sv
// four-stage day count: era, year of era, day of era, signed days since epoch
`default_nettype none
module cdte_days (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_vld,
   input  cdte_pkg::front_type  in_word,
   output logic                 out_vld,
   output cdte_pkg::days_type   out_word
);
   import cdte_pkg::*;

   logic [3:0]        vld_ff;

   // stage 1: era index
   logic [29:0]       era_prod;
   logic [QW-1:0]     q1_in;
   logic [QW-1:0]     q1_ff;
   front_type         w1_ff;

   // stage 2: year of era
   logic [UW-1:0]     yoe_full;
   logic [YoeW-1:0]   yoe2_in;
   logic [YoeW-1:0]   yoe2_ff;
   logic [QW-1:0]     q2_ff;
   front_type         w2_ff;

   // stage 3: day of era and era days
   logic [6:0]        c4;
   logic [14:0]       cent_prod;
   logic [2:0]        c100;
   logic [DoeW-1:0]   doe3_in;
   logic [DoeW-1:0]   doe3_ff;
   logic [QmulW-1:0]  qmul3_in;
   logic [QmulW-1:0]  qmul3_ff;
   front_type         w3_ff;

   // stage 4: days since epoch
   days_type          d4_in;
   days_type          d4_ff;

   always_comb begin
      era_prod = 30'(in_word.ybias[UW-1:4]) * 30'(RecipEra);
      q1_in    = era_prod[RecipEraSh +: QW];

      yoe_full = w1_ff.ybias - UW'(q1_ff) * UW'(EraYears);
      yoe2_in  = yoe_full[YoeW-1:0];

      c4        = yoe2_ff[YoeW-1:2];
      cent_prod = 15'(c4) * 15'(RecipCent);
      c100      = cent_prod[RecipCentSh +: 3];
      doe3_in   = DoeW'(yoe2_ff) * DoeW'(YearDays) + DoeW'(c4) - DoeW'(c100)
                  + DoeW'(w2_ff.doy);
      qmul3_in  = QmulW'(q2_ff) * QmulW'(EraDays);

      d4_in.ok   = w3_ff.ok;
      d4_in.tod  = w3_ff.tod;
      d4_in.days = DaysW'(qmul3_ff) + DaysW'(doe3_ff) - DaysW'(DaysOffset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      q1_ff    <= q1_in;
      w1_ff    <= in_word;
      yoe2_ff  <= yoe2_in;
      q2_ff    <= q1_ff;
      w2_ff    <= w1_ff;
      doe3_ff  <= doe3_in;
      qmul3_ff <= qmul3_in;
      w3_ff    <= w2_ff;
      d4_ff    <= d4_in;
   end

   assign out_vld  = vld_ff[3];
   assign out_word = d4_ff;

endmodule
`default_nettype wire

### sv/cdte_scale.sv
// seconds stage: days times seconds per day, add time of day, zero on bad fields
`default_nettype none
module cdte_scale (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_vld,
   input  cdte_pkg::days_type               in_word,
   output logic                             out_vld,
   output logic                             out_ok,
   output logic [cdte_pkg::EpochW-1:0]      out_secs
);
   import cdte_pkg::*;

   logic [1:0]               vld_ff;
   logic signed [EpochW-1:0] prod_in;
   logic signed [EpochW-1:0] prod_ff;
   logic                     ok1_ff;
   logic [TodW-1:0]          tod1_ff;
   logic [EpochW-1:0]        secs_in;
   logic [EpochW-1:0]        secs_ff;
   logic                     ok2_ff;

   always_comb begin
      prod_in = EpochW'(in_word.days) * $signed(EpochW'(DaySecs));
      secs_in = ok1_ff ? (EpochW'(prod_ff) + EpochW'(tod1_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ok1_ff  <= in_word.ok;
      tod1_ff <= in_word.tod;
      secs_ff <= secs_in;
      ok2_ff  <= ok1_ff;
   end

   assign out_vld  = vld_ff[1];
   assign out_ok   = ok2_ff;
   assign out_secs = secs_ff;

endmodule
`default_nettype wire

### sv/civil_datetime_to_epoch_seconds.sv
// top level: civil date and time to signed epoch seconds
//
// Converts a proleptic Gregorian UTC date and time to signed seconds since
// 1970-01-01 00:00:00. A word is taken on every cycle that start is high;
// busy never rises, so the sustained rate is one word per clock. Each result
// appears on rsp_strobe exactly seven cycles after its start, in order, for
// one cycle only: the receiver must take it then. The latency comes from the
// seven register stages of the pipeline (input decode, era split, year of
// era, day of era, day count, day-to-seconds multiply, final add). Out of
// range fields give rsp_valid_res low and rsp_epoch_seconds zero; a day past
// the end of its month rolls into the following month.
`default_nettype none
module civil_datetime_to_epoch_seconds (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [cdte_pkg::YearW-1:0]       req_year,
   input  wire  [cdte_pkg::MonthW-1:0]      req_month,
   input  wire  [cdte_pkg::DayW-1:0]        req_day,
   input  wire  [cdte_pkg::HourW-1:0]       req_hour,
   input  wire  [cdte_pkg::MinW-1:0]        req_minute,
   input  wire  [cdte_pkg::SecW-1:0]        req_second,
   output logic                             rsp_strobe,
   output logic                             rsp_valid_res,
   output logic [cdte_pkg::EpochW-1:0]      rsp_epoch_seconds
);
   import cdte_pkg::*;

   logic       accept;
   logic       front_vld;
   front_type  front_word;
   logic       days_vld;
   days_type   days_word;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   cdte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (accept),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .hour     (req_hour),
      .minute   (req_minute),
      .second   (req_second),
      .out_vld  (front_vld),
      .out_word (front_word)
   );

   cdte_days u_days (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (front_vld),
      .in_word  (front_word),
      .out_vld  (days_vld),
      .out_word (days_word)
   );

   cdte_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (days_vld),
      .in_word  (days_word),
      .out_vld  (rsp_strobe),
      .out_ok   (rsp_valid_res),
      .out_secs (rsp_epoch_seconds)
   );

endmodule
`default_nettype wire

### sv/cdte_checker.sv
// port-level checks for the converter and their binding to the top level
`default_nettype none
module cdte_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire                          rsp_strobe,
   input wire                          rsp_valid_res,
   input wire [cdte_pkg::EpochW-1:0]   rsp_epoch_seconds
);
   import cdte_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_strobe)
      else $error("accepted word produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, Latency))
      else $error("result without a matching word");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> (rsp_epoch_seconds == '0))
      else $error("invalid result carries nonzero seconds");

endmodule

bind civil_datetime_to_epoch_seconds cdte_checker u_cdte_checker (.*);
`default_nettype wire

### test/testbench.sv
// testbench for civil_datetime_to_epoch_seconds: directed table plus random words against a predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import cdte_pkg::*;

   localparam longint CivilEpochDays = 719468;
   localparam int     RandomWords    = 650;
   localparam int     CycleLimit     = 200000;

   typedef struct packed {
      logic signed [YearW-1:0] year;
      logic [MonthW-1:0]       month;
      logic [DayW-1:0]         day;
      logic [HourW-1:0]        hour;
      logic [MinW-1:0]         minute;
      logic [SecW-1:0]         second;
   } civil_time_type;

   typedef struct packed {
      logic              valid_res;
      logic [EpochW-1:0] epoch_seconds;
   } epoch_word_type;

   typedef struct packed {
      civil_time_type stim;
      logic           typed;
      epoch_word_type known;
   } table_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [YearW-1:0]     req_year;
   logic [MonthW-1:0]    req_month;
   logic [DayW-1:0]      req_day;
   logic [HourW-1:0]     req_hour;
   logic [MinW-1:0]      req_minute;
   logic [SecW-1:0]      req_second;
   logic                 rsp_strobe;
   logic                 rsp_valid_res;
   logic [EpochW-1:0]    rsp_epoch_seconds;

   epoch_word_type pending_epochs[$];
   table_row_type  stim_table[$];
   epoch_word_type head_epoch;
   int             error_count = 0;
   int             cycle_count = 0;
   int             gap_pct;

   civil_datetime_to_epoch_seconds DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_strobe        (rsp_strobe),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic epoch_word_type predict_epoch(input civil_time_type t);
      longint         yr, mon, dom, y, era, yoe, mp, doy, doe, days, secs;
      epoch_word_type r;
      r.valid_res = (t.month >= 1) && (t.month <= 12) && (t.day >= 1) &&
                    (t.hour <= 23) && (t.minute <= 59) && (t.second <= 60);
      secs = 0;
      if (r.valid_res) begin
         yr   = $signed(t.year);
         mon  = t.month;
         dom  = t.day;
         y    = yr - ((mon <= 2) ? 1 : 0);
         era  = ((y >= 0) ? y : y - (EraYears - 1)) / EraYears;
         yoe  = y - era * EraYears;
         mp   = (mon > 2) ? mon - 3 : mon + 9;
         doy  = (153 * mp + 2) / 5 + dom - 1;
         doe  = yoe * YearDays + yoe / 4 - yoe / 100 + doy;
         days = era * EraDays + doe - CivilEpochDays;
         secs = days * DaySecs + longint'(t.hour) * HourSecs +
                longint'(t.minute) * MinSecs + longint'(t.second);
      end
      r.epoch_seconds = secs[EpochW-1:0];
      return r;
   endfunction

   function automatic civil_time_type random_civil_time();
      civil_time_type t;
      case ($urandom_range(3))
         0: t.year = YearW'($urandom_range(16'hFFFF));
         1: t.year = YearW'(1770 + $urandom_range(400));
         2: begin
            case ($urandom_range(5))
               0: t.year = 16'sh8000;
               1: t.year = 16'sh8001;
               2: t.year = 16'sh7FFF;
               3: t.year = 16'sh7FFE;
               4: t.year = 16'sh0000;
               default: t.year = 16'shFFFF;
            endcase
         end
         default: t.year = YearW'($urandom_range(5000) - 2000);
      endcase
      t.month  = ($urandom_range(99) < 85) ? MonthW'($urandom_range(12, 1))
                                           : MonthW'($urandom_range(15));
      t.day    = ($urandom_range(99) < 90) ? DayW'($urandom_range(31, 1))
                                           : DayW'($urandom_range(31));
      t.hour   = ($urandom_range(99) < 90) ? HourW'($urandom_range(23))
                                           : HourW'($urandom_range(31));
      t.minute = ($urandom_range(99) < 90) ? MinW'($urandom_range(59))
                                           : MinW'($urandom_range(63));
      case ($urandom_range(9))
         0: t.second = SecW'(60);
         1: t.second = SecW'($urandom_range(63));
         default: t.second = SecW'($urandom_range(59));
      endcase
      return t;
   endfunction

   task automatic add_row(input int yr, input int mon, input int dom, input int hr,
                          input int mi, input int se, input logic typed,
                          input logic known_valid, input longint known_epoch);
      table_row_type row;
      row.stim.year                = YearW'(yr);
      row.stim.month               = MonthW'(mon);
      row.stim.day                 = DayW'(dom);
      row.stim.hour                = HourW'(hr);
      row.stim.minute              = MinW'(mi);
      row.stim.second              = SecW'(se);
      row.typed                    = typed;
      row.known.valid_res          = known_valid;
      row.known.epoch_seconds      = known_epoch[EpochW-1:0];
      stim_table.push_back(row);
   endtask

   task automatic drive_word(input civil_time_type t, input epoch_word_type expected);
      @(negedge clock);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_year   <= t.year;
      req_month  <= t.month;
      req_day    <= t.day;
      req_hour   <= t.hour;
      req_minute <= t.minute;
      req_second <= t.second;
      do @(posedge clock); while (busy);
      pending_epochs.push_back(expected);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_epochs.size() == 0) begin
            $error("unexpected result word: valid_res %0d epoch_seconds %0d",
                   rsp_valid_res, $signed(rsp_epoch_seconds));
            error_count++;
         end else begin
            head_epoch = pending_epochs.pop_front();
            if (rsp_valid_res !== head_epoch.valid_res) begin
               $error("valid_res: expected %0d, actual %0d",
                      head_epoch.valid_res, rsp_valid_res);
               error_count++;
            end
            if (rsp_epoch_seconds !== head_epoch.epoch_seconds) begin
               $error("epoch_seconds: expected %0d, actual %0d",
                      $signed(head_epoch.epoch_seconds), $signed(rsp_epoch_seconds));
               error_count++;
            end
         end
      end
   end

   initial begin
      civil_time_type t;
      gap_pct     = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_year    = '0;
      req_month   = '0;
      req_day     = '0;
      req_hour    = '0;
      req_minute  = '0;
      req_second  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // epoch neighborhood and leap second
      add_row(1970, 1, 1, 0, 0, 0, 1'b1, 1'b1, 0);
      add_row(1970, 1, 1, 0, 0, 1, 1'b1, 1'b1, 1);
      add_row(1969, 12, 31, 23, 59, 59, 1'b1, 1'b1, -1);
      add_row(1970, 1, 1, 0, 0, 60, 1'b1, 1'b1, 60);
      add_row(1970, 1, 1, 0, 1, 0, 1'b1, 1'b1, 60);
      add_row(1970, 1, 2, 0, 0, 0, 1'b1, 1'b1, 86400);
      // out of range fields
      add_row(1970, 0, 1, 0, 0, 0, 1'b1, 1'b0, 0);
      add_row(1970, 13, 1, 0, 0, 0, 1'b1, 1'b0, 0);
      add_row(2024, 15, 31, 23, 59, 60, 1'b1, 1'b0, 0);
      add_row(1970, 1, 0, 0, 0, 0, 1'b1, 1'b0, 0);
      add_row(1970, 1, 1, 24, 0, 0, 1'b1, 1'b0, 0);
      add_row(1970, 1, 1, 31, 0, 0, 1'b1, 1'b0, 0);
      add_row(1970, 1, 1, 0, 60, 0, 1'b1, 1'b0, 0);
      add_row(1970, 1, 1, 0, 63, 0, 1'b1, 1'b0, 0);
      add_row(1970, 1, 1, 0, 0, 61, 1'b1, 1'b0, 0);
      add_row(-32768, 15, 31, 31, 63, 63, 1'b1, 1'b0, 0);
      // year extremes, leap years, day past month end
      add_row(-32768, 1, 1, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(32767, 12, 31, 23, 59, 60, 1'b0, 1'b0, 0);
      add_row(-32768, 2, 31, 12, 30, 30, 1'b0, 1'b0, 0);
      add_row(2000, 2, 29, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(2000, 2, 31, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(1900, 2, 29, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(0, 1, 1, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(-1, 3, 1, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(2024, 4, 31, 23, 59, 59, 1'b0, 1'b0, 0);

      foreach (stim_table[i]) begin
         drive_word(stim_table[i].stim, stim_table[i].typed ? stim_table[i].known
                                                            : predict_epoch(stim_table[i].stim));
      end

      // hold off until the pipeline drains
      @(negedge clock);
      start <= 1'b0;
      while (pending_epochs.size() != 0) @(negedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       gap_pct = 64;
            3:       gap_pct = 38;
            default: gap_pct = 0;
         endcase
         for (int n = 0; n < RandomWords / 4; n++) begin
            t = random_civil_time();
            drive_word(t, predict_epoch(t));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
      repeat (2 * Latency) @(posedge clock);
      if (error_count == 0 && pending_epochs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
